>>> hw/rtl/positional_list_engine_josephus_top_defines.svh
// Assertion macros used by the controller.
`ifndef POSITIONAL_LIST_ENGINE_JOSEPHUS_TOP_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_JOSEPHUS_TOP_DEFINES_SVH
// Antecedent implies consequent on the same edge.
`define PLJ_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Antecedent implies consequent on the next edge.
`define PLJ_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

>>> hw/rtl/plj_pkg.sv
`default_nettype none
package plj_pkg;
  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned VAL_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_LOCATE   = 2'd2,
    OP_JOSEPHUS = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_LOC_RD,
    S_LOC_CMP,
    S_JOS_MOD,
    S_JOS_RD,
    S_JOS_CAP,
    S_RESULT,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic ins_rd;     // read entry at ptr-1
    logic ins_wr;     // write read data at ptr, ptr--
    logic ins_fin;    // write value at position, count++
    logic del_rd;     // read entry at ptr+1
    logic del_wr;     // write read data at ptr, ptr++
    logic del_fin;    // count--
    logic loc_rd;     // read entry at ptr
    logic loc_cmp;    // compare read data with value
    logic loc_next;   // ptr++
    logic mod_init;   // start modulo reduction
    logic mod_step;   // one conditional subtract
    logic jos_rd;     // read entry at idx
    logic jos_cap;    // capture removed value, set up shift
    logic res_load;   // build result register
    logic res_take;   // result taken
  } plj_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic full;
    logic empty;
    logic ins_bad;
    logic del_bad;
    logic ins_done;   // ptr reached insert position
    logic del_done;   // ptr+1 reached count
    logic loc_hit;
    logic loc_end;    // ptr at last entry
    logic mod_done;
    logic jos_more;   // entries remain after this removal
  } plj_sts_t;
endpackage
`default_nettype wire

>>> hw/rtl/plj_ram.sv
`default_nettype none
module plj_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/plj_datapath.sv
`default_nettype none
module plj_datapath #(
  parameter int unsigned CAPACITY = plj_pkg::CAPACITY_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire plj_pkg::plj_cmd_t   cmd,
  output      plj_pkg::plj_sts_t   sts,
  input  wire logic [1:0]          in_op,
  input  wire logic [6:0]          in_position,
  input  wire logic signed [31:0]  in_item_value,
  input  wire logic [6:0]          in_start_place,
  input  wire logic [15:0]         in_step_count,
  output      logic [2:0]          out_status,
  output      logic [5:0]          out_found_index,
  output      logic signed [31:0]  out_out_value,
  output      logic [6:0]          out_fill_count,
  output      logic                out_last
);
  import plj_pkg::*;
  localparam int unsigned AW = $clog2(CAPACITY);
  // dividend start + step + 2*count fits in 17 bits; count << 16 needs 23
  localparam int unsigned DW = 23;

  logic [6:0]  count_r, count_nxt;
  logic [1:0]  op_r;
  logic [6:0]  pos_r;
  logic [31:0] val_r;
  logic [6:0]  start_r;
  logic [15:0] step_r;
  logic [6:0]  ptr_r, ptr_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dsub_r, dsub_nxt;   // count shifted left, halves per step
  logic [4:0]  sh_r, sh_nxt;
  logic [6:0]  acc_r, acc_nxt;
  logic        first_r, first_nxt;
  logic [31:0] wval_r;
  logic [5:0]  widx_r;
  logic        hit_r;

  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;

  plj_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = ptr_r[AW-1:0];
    wdata = rdata;
    raddr = ptr_r[AW-1:0];
    if (cmd.ins_rd) raddr = AW'(ptr_r - 7'd1);
    if (cmd.del_rd) raddr = AW'(ptr_r + 7'd1);
    if (cmd.jos_rd) raddr = rem_r[AW-1:0];
    if (cmd.ins_wr || cmd.del_wr) we = 1'b1;
    if (cmd.ins_fin) begin
      we    = 1'b1;
      // an empty list takes the value at slot 0 whatever the position
      waddr = (count_r == 7'd0) ? '0 : pos_r[AW-1:0];
      wdata = val_r;
    end
  end

  // sequential modulo: restoring subtract of count << k
  always_comb begin
    rem_nxt  = rem_r;
    dsub_nxt = dsub_r;
    sh_nxt   = sh_r;
    if (cmd.mod_init) begin
      rem_nxt  = DW'(first_r ? start_r : acc_r) + DW'(step_r)
                 + DW'({count_r, 1'b0}) - DW'(2);
      dsub_nxt = DW'(count_r) << 16;
      sh_nxt   = 5'd16;
    end else if (cmd.mod_step) begin
      if (rem_r >= dsub_r) rem_nxt = rem_r - dsub_r;
      dsub_nxt = dsub_r >> 1;
      sh_nxt   = sh_r - 5'd1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    acc_nxt   = acc_r;
    first_nxt = first_r;
    if (cmd.load) begin
      ptr_nxt   = (in_op == OP_INSERT) ? count_r : ((in_op == OP_DELETE) ? in_position : 7'd0);
      first_nxt = 1'b1;
    end
    if (cmd.ins_wr) ptr_nxt = ptr_r - 7'd1;
    if (cmd.ins_fin) count_nxt = (count_r == 7'd0) ? 7'd1 : count_r + 7'd1;
    if (cmd.del_wr) ptr_nxt = ptr_r + 7'd1;
    if (cmd.del_fin) count_nxt = count_r - 7'd1;
    if (cmd.loc_next) ptr_nxt = ptr_r + 7'd1;
    if (cmd.jos_cap) begin
      ptr_nxt   = {1'b0, rem_r[5:0]};
      acc_nxt   = 7'(rem_r[5:0]) + 7'd1;
      first_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    ptr_r   <= ptr_nxt;
    rem_r   <= rem_nxt;
    dsub_r  <= dsub_nxt;
    sh_r    <= sh_nxt;
    acc_r   <= acc_nxt;
    first_r <= first_nxt;
    hit_r   <= cmd.loc_rd ? 1'b0 : ((cmd.loc_cmp && (rdata == val_r)) ? 1'b1 : hit_r);
    if (cmd.load) begin
      op_r    <= in_op;
      pos_r   <= in_position;
      val_r   <= in_item_value;
      start_r <= in_start_place;
      step_r  <= in_step_count;
    end
    if (cmd.jos_cap) begin
      wval_r <= rdata;
      widx_r <= rem_r[5:0];
    end
  end

  always_comb begin
    sts.op       = op_r;
    sts.full     = (count_r >= 7'(CAPACITY));
    sts.empty    = (count_r == 7'd0);
    sts.ins_bad  = (pos_r > count_r);
    // position check only for a delete item; josephus removals are always in range
    sts.del_bad  = (op_r == OP_DELETE) && (pos_r >= count_r);
    sts.ins_done = (ptr_r <= pos_r);
    sts.del_done = (7'(ptr_r + 7'd1) >= count_r);
    sts.loc_hit  = (rdata == val_r);
    sts.loc_end  = (7'(ptr_r + 7'd1) >= count_r);
    sts.mod_done = (sh_r == 5'd0) && !cmd.mod_init;
    sts.jos_more = (count_r != 7'd0);
  end

  // result register; status chosen here from op and flags, insert/delete failures come from the controller
  logic [2:0] res_status;
  logic [5:0] res_idx;
  logic [31:0] res_val;
  logic        res_last;
  always_comb begin
    res_status = ST_OK;
    res_idx    = '0;
    res_val    = '0;
    res_last   = 1'b1;
    case (op_r)
      OP_INSERT: begin
        if (count_r >= 7'(CAPACITY) && !first_r) res_status = ST_OK;
      end
      OP_LOCATE: begin
        if (hit_r) res_idx = ptr_r[5:0];
        else res_status = ST_NOTFOUND;
      end
      OP_JOSEPHUS: begin
        if (first_r) begin
          res_status = ST_EMPTY;
        end else begin
          res_idx  = widx_r;
          res_val  = wval_r;
          res_last = (count_r == 7'd0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status      <= res_status;
      out_found_index <= res_idx;
      out_out_value   <= res_val;
      out_fill_count  <= count_nxt;
      out_last        <= res_last;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/positional_list_engine_josephus_top.sv
// Sequence: insert/delete read and write each shifted entry, then show the result;
//   locate reads and compares each entry scanned; josephus runs, per removal, a
//   modulo reduction, read, capture, shift of the entries behind it and result.
// Throughput: one item at a time; next item accepted once its last result is taken.
// Reset: synchronous active-low rst_n empties the list; entry RAM is not cleared.
`default_nettype none
module positional_list_engine_josephus_top #(
  parameter int unsigned CAPACITY = plj_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [1:0]         in_op,
  input  wire logic [6:0]         in_position,
  input  wire logic signed [31:0] in_item_value,
  input  wire logic [6:0]         in_start_place,
  input  wire logic [15:0]        in_step_count,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [2:0]         out_status,
  output      logic [5:0]         out_found_index,
  output      logic signed [31:0] out_out_value,
  output      logic [6:0]         out_fill_count,
  output      logic               out_last
);
  import plj_pkg::*;
  plj_cmd_t cmd;
  plj_sts_t sts;
  status_t  ctl_status;
  logic [2:0] dp_status;

  plj_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_op(in_op), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd),
    .res_status(ctl_status)
  );

  plj_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_op(in_op), .in_position(in_position), .in_item_value(in_item_value),
    .in_start_place(in_start_place), .in_step_count(in_step_count),
    .out_status(dp_status), .out_found_index(out_found_index),
    .out_out_value(out_out_value), .out_fill_count(out_fill_count), .out_last(out_last)
  );

  // insert/delete failure codes come from the controller
  logic [2:0] st_r;
  always_ff @(posedge clk) begin
    if (cmd.res_load) st_r <= ctl_status;
  end
  assign out_status = (st_r == ST_OK) ? dp_status : st_r;
endmodule
`default_nettype wire

>>> hw/rtl/plj_ctrl.sv
`default_nettype none
`include "positional_list_engine_josephus_top_defines.svh"
module plj_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_op,
  output      logic              in_ready,
  output      logic              out_valid,
  input  wire logic              out_ready,
  input  wire plj_pkg::plj_sts_t sts,
  output      plj_pkg::plj_cmd_t cmd,
  output      plj_pkg::status_t  res_status
);
  import plj_pkg::*;
  state_t state_r, state_nxt;
  logic mod_started_r;
  logic del_ok_r;
  logic ins_ok_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = (in_op == OP_INSERT) ? S_INS_RD :
                   (in_op == OP_DELETE) ? S_DEL_RD :
                   (in_op == OP_LOCATE) ? S_LOC_RD : S_JOS_MOD;
      S_INS_RD:  state_nxt = (sts.full || sts.empty || sts.ins_bad || sts.ins_done)
                   ? S_RESULT : S_INS_WR;
      S_INS_WR:  state_nxt = S_INS_RD;
      S_DEL_RD:  state_nxt = (sts.del_bad || sts.del_done) ? S_RESULT : S_DEL_WR;
      S_DEL_WR:  state_nxt = S_DEL_RD;
      S_LOC_RD:  state_nxt = sts.empty ? S_RESULT : S_LOC_CMP;
      S_LOC_CMP: state_nxt = (sts.loc_hit || sts.loc_end) ? S_RESULT : S_LOC_RD;
      S_JOS_MOD: state_nxt = sts.empty ? S_RESULT : (sts.mod_done ? S_JOS_RD : S_JOS_MOD);
      S_JOS_RD:  state_nxt = S_JOS_CAP;
      S_JOS_CAP: state_nxt = S_DEL_RD;
      S_RESULT:  state_nxt = S_OUT;
      S_OUT:     if (out_ready) state_nxt = (sts.op == OP_JOSEPHUS && sts.jos_more)
                   ? S_JOS_MOD : S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    res_status = ST_OK;
    case (state_r)
      S_IDLE:    cmd.load = in_valid;
      S_INS_RD:  begin
        cmd.ins_rd = 1'b1;
        if (!(sts.full || sts.ins_bad) || sts.empty) begin
          if (sts.empty || sts.ins_done) cmd.ins_fin = !sts.full;
        end
      end
      S_INS_WR:  cmd.ins_wr = 1'b1;
      S_DEL_RD:  begin
        cmd.del_rd = 1'b1;
        if (!sts.del_bad && sts.del_done) cmd.del_fin = 1'b1;
      end
      S_DEL_WR:  cmd.del_wr = 1'b1;
      S_LOC_RD:  cmd.loc_rd = 1'b1;
      S_LOC_CMP: begin
        cmd.loc_cmp = 1'b1;
        if (!(sts.loc_hit || sts.loc_end)) cmd.loc_next = 1'b1;
      end
      S_JOS_MOD: begin
        cmd.mod_init = !mod_started_r;
        cmd.mod_step = mod_started_r;
      end
      S_JOS_RD:  cmd.jos_rd = 1'b1;
      S_JOS_CAP: cmd.jos_cap = 1'b1;
      S_RESULT:  cmd.res_load = 1'b1;
      S_OUT:     cmd.res_take = out_ready;
      default:   ;
    endcase
    // flags are judged on the count before a successful insert or delete
    if (sts.op == OP_INSERT && !ins_ok_r && sts.full) res_status = ST_FULL;
    else if (sts.op == OP_INSERT && !ins_ok_r && !sts.empty && sts.ins_bad)
      res_status = ST_BADPOS;
    else if (sts.op == OP_DELETE && sts.del_bad && !del_ok_r) res_status = ST_BADPOS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      mod_started_r <= 1'b0;
      del_ok_r      <= 1'b0;
      ins_ok_r      <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      mod_started_r <= (state_r == S_JOS_MOD) && !sts.mod_done;
      if (cmd.load) begin
        del_ok_r <= 1'b0;
        ins_ok_r <= 1'b0;
      end
      if (cmd.del_fin) del_ok_r <= 1'b1;
      if (cmd.ins_fin) ins_ok_r <= 1'b1;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  `PLJ_ASSERT_IMP(a_excl, clk, rst_n, 1'b1, !(in_ready && out_valid), "ready and valid both high")
  `PLJ_ASSERT_NXT(a_load, clk, rst_n, in_valid && in_ready, !in_ready, "item not captured")
  `PLJ_ASSERT_NXT(a_res, clk, rst_n, cmd.res_load, out_valid, "result not shown")
endmodule
`default_nettype wire

>>> bench/plj_list_checker.sv
`timescale 1ns / 1ps
module plj_list_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [6:0]         in_position,
  input  logic signed [31:0] in_item_value,
  input  logic [6:0]         in_start_place,
  input  logic [15:0]        in_step_count,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         out_status,
  input  logic [5:0]         out_found_index,
  input  logic signed [31:0] out_out_value,
  input  logic [6:0]         out_fill_count,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen
);
  import plj_pkg::*;

  localparam int unsigned SLOTS = 64;

  typedef struct packed {
    status_t            status;
    logic [5:0]         found_index;
    logic signed [31:0] value;
    logic [6:0]         fill;
    logic               last;
  } list_result_t;

  logic signed [31:0] shadow_list [SLOTS];
  int unsigned        shadow_count;
  list_result_t       expected_q[$];

  task automatic report(input string what, input longint want, input longint got);
    $display("tb: mismatch on %s at %0t: expected %0d, got %0d", what, $time, want, got);
    fail_count++;
  endtask

  function automatic list_result_t make_result(status_t st, int unsigned idx,
                                               logic signed [31:0] v, logic lst);
    list_result_t r;
    r.status      = st;
    r.found_index = idx[5:0];
    r.value       = v;
    r.fill        = shadow_count[6:0];
    r.last        = lst;
    return r;
  endfunction

  // removes one entry and closes the gap
  task automatic drop_entry(input int unsigned p);
    for (int unsigned q = p; q + 1 < shadow_count; q++) shadow_list[q] = shadow_list[q + 1];
    shadow_count--;
  endtask

  task automatic predict_item(input op_t op, input int unsigned pos,
                              input logic signed [31:0] v, input int unsigned s,
                              input int unsigned m);
    int unsigned acc;
    int unsigned idx;
    logic signed [31:0] w;
    bit hit;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= SLOTS) begin
          expected_q.push_back(make_result(ST_FULL, 0, 0, 1'b1));
        end else if (shadow_count == 0) begin
          shadow_list[0] = v;
          shadow_count = 1;
          expected_q.push_back(make_result(ST_OK, 0, 0, 1'b1));
        end else if (pos > shadow_count) begin
          expected_q.push_back(make_result(ST_BADPOS, 0, 0, 1'b1));
        end else begin
          for (int unsigned q = shadow_count; q > pos; q--) shadow_list[q] = shadow_list[q - 1];
          shadow_list[pos] = v;
          shadow_count++;
          expected_q.push_back(make_result(ST_OK, 0, 0, 1'b1));
        end
      end
      OP_DELETE: begin
        if (pos >= shadow_count) begin
          expected_q.push_back(make_result(ST_BADPOS, 0, 0, 1'b1));
        end else begin
          drop_entry(pos);
          expected_q.push_back(make_result(ST_OK, 0, 0, 1'b1));
        end
      end
      OP_LOCATE: begin
        hit = 1'b0;
        for (int unsigned q = 0; q < shadow_count && !hit; q++) begin
          if (shadow_list[q] == v) begin
            hit = 1'b1;
            expected_q.push_back(make_result(ST_OK, q, 0, 1'b1));
          end
        end
        if (!hit) expected_q.push_back(make_result(ST_NOTFOUND, 0, 0, 1'b1));
      end
      default: begin
        if (shadow_count == 0) begin
          expected_q.push_back(make_result(ST_EMPTY, 0, 0, 1'b1));
        end else begin
          acc = s;
          for (int unsigned i = shadow_count; i > 0; i--) begin
            idx = (acc + m + 2 * i - 2) % i;
            w = shadow_list[idx];
            drop_entry(idx);
            expected_q.push_back(make_result(ST_OK, idx, w, i == 1));
            acc = idx + 1;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      shadow_count = 0;
      expected_q.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (in_valid && in_ready)
        predict_item(op_t'(in_op), in_position, in_item_value, in_start_place, in_step_count);
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $display("tb: unexpected item on result channel at %0t", $time);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_status !== want.status) report("status", want.status, out_status);
          if (out_found_index !== want.found_index)
            report("found_index", want.found_index, out_found_index);
          if (out_out_value !== want.value) report("out_value", want.value, out_out_value);
          if (out_fill_count !== want.fill) report("fill_count", want.fill, out_fill_count);
          if (out_last !== want.last) report("last", want.last, out_last);
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

>>> bench/positional_list_engine_josephus_top_tb.sv
`timescale 1ns / 1ps
module positional_list_engine_josephus_top_tb;
  import plj_pkg::*;

  localparam int LIMIT      = 2_000_000;
  localparam int ITEM_GOAL  = 150;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_op;
  logic [6:0]         in_position;
  logic signed [31:0] in_item_value;
  logic [6:0]         in_start_place;
  logic [15:0]        in_step_count;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_status;
  logic [5:0]         out_found_index;
  logic signed [31:0] out_out_value;
  logic [6:0]         out_fill_count;
  logic               out_last;

  int fail_count;
  int pending;
  int results_seen;
  int cycles;
  int items_sent;
  int list_fill;      // entry count as the stimulus sees it, used to aim positions and to fill to capacity
  int burst_left;
  int hold_off;       // long receiver hold-off, counted down by the receiver process
  int joseph_runs;

  logic signed [31:0] value_pool [8];

  positional_list_engine_josephus_top dut (.*);

  plj_list_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_position, .in_item_value,
    .in_start_place, .in_step_count, .out_valid, .out_ready, .out_status,
    .out_found_index, .out_out_value, .out_fill_count, .out_last,
    .fail_count, .pending, .results_seen
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Receiver: a mode is picked each time phase wraps - always ready, coin flip, or
  // mostly stalled. A nonzero hold_off overrides it with a long stall.
  initial begin
    int mode;
    int phase;
    out_ready = 1'b0;
    mode = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (phase == 0) mode = $urandom_range(0, 2);
      phase = (phase + 1) % 32;
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one item and wait for it to be taken. Gaps between bursts are
  // inserted here; valid stays up across back-to-back items of a burst.
  task automatic send_item(input op_t op, input int pos, input logic signed [31:0] v,
                           input int s, input int m);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_op          <= op;
    in_position    <= pos[6:0];
    in_item_value  <= v;
    in_start_place <= s[6:0];
    in_step_count  <= m[15:0];
    do @(posedge clk); while (!in_ready);
    items_sent++;
    // track the fill level so positions can be aimed at the live range
    case (op)
      OP_INSERT: if (list_fill < 64 && (list_fill == 0 || pos <= list_fill)) list_fill++;
      OP_DELETE: if (pos < list_fill) list_fill--;
      OP_JOSEPHUS: begin
        list_fill = 0;
        joseph_runs++;
      end
      default: ;
    endcase
  endtask

  task automatic idle_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 1)) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  initial begin
    int roll;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = OP_INSERT;
    in_position    = '0;
    in_item_value  = '0;
    in_start_place = 7'd1;
    in_step_count  = 16'd1;
    hold_off       = 0;
    items_sent     = 0;
    list_fill      = 0;
    burst_left     = 0;
    joseph_runs    = 0;
    foreach (value_pool[i]) value_pool[i] = $urandom;
    value_pool[0] = 32'sh7fffffff;
    value_pool[1] = 32'sh80000000;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed: empty-list cases, insert edge rules, locate, delete, josephus wrap
    send_item(OP_JOSEPHUS, 0, 0, 1, 1);              // josephus on empty list
    send_item(OP_DELETE, 0, 0, 1, 1);                // delete on empty list
    send_item(OP_LOCATE, 0, 0, 1, 1);                // locate miss on empty list
    send_item(OP_INSERT, 127, 32'sh7fffffff, 1, 1);  // empty: lands at slot 0
    send_item(OP_INSERT, 5, 32'sd7, 1, 1);           // beyond the end
    send_item(OP_INSERT, 0, 32'sh80000000, 1, 1);
    send_item(OP_INSERT, 2, -32'sd1, 1, 1);          // append at the end
    send_item(OP_INSERT, 1, 32'sd0, 1, 1);
    send_item(OP_LOCATE, 0, 32'sh80000000, 1, 1);
    send_item(OP_LOCATE, 0, 32'sd12345, 1, 1);
    send_item(OP_LOCATE, 0, -32'sd1, 1, 1);
    send_item(OP_DELETE, 4, 0, 1, 1);                // position equal to count
    send_item(OP_DELETE, 127, 0, 1, 1);
    send_item(OP_DELETE, 3, 0, 1, 1);                // last entry
    send_item(OP_DELETE, 0, 0, 1, 1);
    send_item(OP_JOSEPHUS, 0, 0, 0, 0);              // start zero, step zero
    send_item(OP_INSERT, 0, 32'sd11, 1, 1);
    send_item(OP_INSERT, 1, 32'sd22, 1, 1);
    send_item(OP_INSERT, 2, 32'sd33, 1, 1);
    send_item(OP_JOSEPHUS, 0, 0, 127, 65535);        // largest start and step
    send_item(OP_INSERT, 0, 32'sd44, 1, 1);
    send_item(OP_INSERT, 0, 32'sd55, 1, 1);
    send_item(OP_JOSEPHUS, 0, 0, 1, 1);

    // sender pauses until every result is back
    idle_until_drained();

    // --- fill to capacity while the receiver holds off for a long stretch
    hold_off = 400;
    while (list_fill < 64)
      send_item(OP_INSERT, $urandom_range(0, list_fill), pick_value(), 1, 1);
    send_item(OP_INSERT, 0, 32'sd1, 1, 1);           // full
    send_item(OP_INSERT, 100, 32'sd2, 1, 1);         // full wins over bad position
    send_item(OP_LOCATE, 0, value_pool[$urandom_range(0, 7)], 1, 1);
    send_item(OP_JOSEPHUS, 0, 0, $urandom_range(1, 64), $urandom_range(1, 200));

    // --- random mix, mostly well-aimed
    while (items_sent < ITEM_GOAL) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        if ($urandom_range(0, 9) == 0)
          send_item(OP_INSERT, $urandom_range(0, 127), pick_value(),
                    $urandom_range(0, 127), $urandom_range(0, 65535));
        else
          send_item(OP_INSERT, $urandom_range(0, list_fill), pick_value(),
                    $urandom_range(0, 127), $urandom_range(0, 65535));
      end else if (roll < 65) begin
        if (list_fill > 0 && $urandom_range(0, 4) != 0)
          send_item(OP_DELETE, $urandom_range(0, list_fill - 1), $urandom, 1, 1);
        else
          send_item(OP_DELETE, $urandom_range(0, 127), $urandom, 1, 1);
      end else if (roll < 90) begin
        send_item(OP_LOCATE, $urandom_range(0, 127), pick_value(), 1, 1);
      end else if ($urandom_range(0, 3) == 0) begin
        send_item(OP_JOSEPHUS, $urandom_range(0, 127), $urandom,
                  $urandom_range(0, 127), $urandom_range(0, 65535));
      end else begin
        send_item(OP_JOSEPHUS, 0, 0, $urandom_range(1, 64), $urandom_range(1, 300));
      end
    end

    idle_until_drained();
    repeat (300) @(posedge clk);
    $display("tb: %0d items sent, %0d results checked, %0d josephus runs",
             items_sent, results_seen, joseph_runs);
    $display("tb: list filled to capacity once, long receiver stall exercised");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/plj_pkg.sv
hw/rtl/plj_ram.sv
hw/rtl/plj_datapath.sv
hw/rtl/positional_list_engine_josephus_top.sv
hw/rtl/plj_ctrl.sv
bench/plj_list_checker.sv
bench/positional_list_engine_josephus_top_tb.sv
